// ===== rtl/roce_pkg.sv =====
`timescale 1ns / 1ps
package roce_pkg;

  // Field widths of the input and result words.
  localparam int unsigned ActW   = 2;
  localparam int unsigned StartW = 32;
  localparam int unsigned WidthW = 31;
  localparam int unsigned SpaceW = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LrcW   = 5;

  // Action codes; the last one is unused and ignored.
  localparam logic [ActW-1:0] ACT_APPEND = 2'd0;
  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd1;
  localparam logic [ActW-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ActW-1:0] ACT_RSVD   = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

  // Characters.
  localparam logic [CharW-1:0] CH_G     = 8'h67;
  localparam logic [CharW-1:0] CH_X     = 8'h58;
  localparam logic [CharW-1:0] CH_M     = 8'h6d;
  localparam logic [CharW-1:0] CH_A     = 8'h61;
  localparam logic [CharW-1:0] CH_COLON = 8'h3a;
  localparam logic [CharW-1:0] CH_GT    = 8'h3e;
  localparam logic [CharW-1:0] CH_LT    = 8'h3c;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic signed [7:0] CLS_MIN = -8'sd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_WALK,
    S_PREP,
    S_RD,
    S_OUT
  } state_e;

  // Overlap class letter of a query against one subject; ends are exclusive.
  function automatic logic [CharW-1:0] class_char(input logic signed [33:0] qs,
                                                  input logic signed [33:0] qe,
                                                  input logic signed [33:0] ss,
                                                  input logic signed [33:0] se);
    logic signed [7:0] c;
    if (qe < ss) c = CLS_MIN;
    else if (qe == ss) c = -8'sd5;
    else if (se < qs) c = 8'sd6;
    else if (se == qs) c = 8'sd5;
    else if (qs < ss) c = (qe < se) ? -8'sd4 : ((qe == se) ? -8'sd3 : -8'sd2);
    else if (qs == ss) c = (qe < se) ? -8'sd1 : ((qe == se) ? 8'sd0 : 8'sd1);
    else c = (qe < se) ? 8'sd2 : ((qe == se) ? 8'sd3 : 8'sd4);
    return CH_G + c;
  endfunction

  // Binary to three BCD digits by shift and add-three.
  function automatic logic [11:0] bin2bcd(input logic [8:0] v);
    logic [11:0] b;
    b = '0;
    for (int i = 8; i >= 0; i--) begin
      if (b[3:0] > 4'd4) b[3:0] = b[3:0] + 4'd3;
      if (b[7:4] > 4'd4) b[7:4] = b[7:4] + 4'd3;
      if (b[11:8] > 4'd4) b[11:8] = b[11:8] + 4'd3;
      b = {b[10:0], v[i]};
    end
    return b;
  endfunction

endpackage

// ===== rtl/roce_if.sv =====
`timescale 1ns / 1ps
// Input word channel.
interface roce_in_if;
  logic                             valid;
  logic                             ready;
  logic [roce_pkg::ActW-1:0]        action;
  logic signed [roce_pkg::StartW-1:0] range_start;
  logic [roce_pkg::WidthW-1:0]      range_width;
  logic signed [roce_pkg::SpaceW-1:0] range_space;
  logic                             first_row;
  modport source (output valid, action, range_start, range_width, range_space, first_row,
                  input ready);
  modport sink (input valid, action, range_start, range_width, range_space, first_row,
                output ready);
endinterface

// Result word channel.
interface roce_out_if;
  logic                        valid;
  logic                        ready;
  logic [roce_pkg::CharW-1:0]  out_char;
  logic [roce_pkg::StatW-1:0]  status;
  logic                        last;
  modport source (output valid, out_char, status, last, input ready);
  modport sink (input valid, out_char, status, last, output ready);
endinterface

// Configuration write channel carrying sparse_mode.
interface roce_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/range_overlap_code_encoder_core.sv =====
`timescale 1ns / 1ps
// An append or clear is taken in the idle state; a full-table append or empty sparse query
// gives its status word through the error state and the output register.
// A query walks the N stored subjects, lays out the row in the prep state, then emits each
// of its L result words through a code memory read, then the output register.
// Items are handled one at a time.
// Reset is asynchronous active low: table empty, last column zero, sparse mode on.
module range_overlap_code_encoder_core #(
  parameter int unsigned MAX_SUBJECTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  roce_cfg_if.sink     cfg_i,
  roce_in_if.sink      in_i,
  roce_out_if.source   out_o
);

  localparam int unsigned AW  = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_SUBJECTS + 1);
  localparam int unsigned BUF = 2 * MAX_SUBJECTS + 8;
  localparam int unsigned PW  = $clog2(BUF + MAX_SUBJECTS + 40);
  localparam int unsigned EW  = roce_pkg::StartW + roce_pkg::WidthW + roce_pkg::SpaceW;

  roce_pkg::state_e state_q, state_d;

  logic            mode_q;
  logic [CW-1:0]   cnt_q;
  logic [roce_pkg::LrcW-1:0] lrc_q;

  // Query word.
  logic signed [33:0] qs_q, qe_q;
  logic [roce_pkg::SpaceW-1:0] qsp_q;
  logic            first_q;
  logic [CW-1:0]   n_q;
  logic [roce_pkg::StatW-1:0] err_q;

  // Walk over the subject table.
  logic [CW-1:0]   rd_idx_q;
  logic            cmp_vld_q;
  logic [AW-1:0]   cmp_idx_q;
  logic            found_q;
  logic [CW-1:0]   j1_q, j2_q;

  // Emission.
  logic [PW-1:0]   k_q, colon_q, pfx_q, total_q, base_q;
  logic            dec_q, neg_q;
  logic [1:0]      ndig_q;
  logic [11:0]     bcd_q;

  logic                      out_vld_q, out_last_q;
  logic [roce_pkg::CharW-1:0] out_char_q;
  logic [roce_pkg::StatW-1:0] out_stat_q;

  // Memories.
  logic [EW-1:0]             subj_mem [MAX_SUBJECTS];
  logic [EW-1:0]             subj_rd_q;
  logic [roce_pkg::CharW-1:0] code_mem [MAX_SUBJECTS];
  logic [roce_pkg::CharW-1:0] code_rd_q;

  logic in_acc, out_free, out_load;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign out_load = (state_q == roce_pkg::S_ERR || state_q == roce_pkg::S_OUT) && out_free;

  // Compare stage: subject read back from the table.
  logic signed [33:0] ss, se;
  logic [roce_pkg::SpaceW-1:0] ssp;
  logic [roce_pkg::CharW-1:0]  cmp_char;
  always_comb begin
    ss  = {{2{subj_rd_q[EW-1]}}, subj_rd_q[EW-1 -: roce_pkg::StartW]};
    se  = ss + $signed({3'b000, subj_rd_q[roce_pkg::SpaceW +: roce_pkg::WidthW]});
    ssp = subj_rd_q[roce_pkg::SpaceW-1:0];
    if (qsp_q == '1 || ssp == '1 || qsp_q != ssp) cmp_char = roce_pkg::CH_X;
    else cmp_char = roce_pkg::class_char(qs_q, qe_q, ss, se);
  end

  // Row layout, worked out once after the walk.
  logic [PW-1:0] j1w, j2w, nw, colon_w, pre_w, ncode_w, sum_w, base_w;
  logic [PW-1:0] lrc_eff;
  logic signed [PW:0] shift_w;
  logic [11:0]   bcd_w;
  logic [1:0]    ndig_w;
  always_comb begin
    j1w     = PW'(j1_q);
    j2w     = PW'(j2_q);
    nw      = PW'(n_q);
    lrc_eff = first_q ? '0 : PW'(lrc_q);
    bcd_w   = roce_pkg::bin2bcd(9'(j1_q));
    ndig_w  = (bcd_w[11:8] != 4'd0) ? 2'd3 : ((bcd_w[7:4] != 4'd0) ? 2'd2 : 2'd1);
    shift_w = $signed({1'b0, j1w}) - $signed({1'b0, lrc_eff}) - $signed((PW+1)'(1));
    if (mode_q) begin
      colon_w = first_q ? '0 : PW'(1);
      if (lrc_eff == '0) pre_w = PW'(ndig_w);
      else if (shift_w < 0) pre_w = PW'(-shift_w);
      else pre_w = PW'(shift_w);
      ncode_w = j2w - j1w + PW'(1);
      base_w  = j1w - PW'(1);
    end else begin
      colon_w = '0;
      pre_w   = '0;
      ncode_w = nw;
      base_w  = '0;
    end
    sum_w = colon_w + pre_w + ncode_w;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      roce_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_i.action == roce_pkg::ACT_APPEND) begin
            if (cnt_q >= CW'(MAX_SUBJECTS)) state_d = roce_pkg::S_ERR;
          end else if (in_i.action == roce_pkg::ACT_QUERY) begin
            if (cnt_q != '0) state_d = roce_pkg::S_WALK;
            else if (mode_q) state_d = roce_pkg::S_ERR;
          end
        end
      end
      roce_pkg::S_ERR:  if (out_free) state_d = roce_pkg::S_IDLE;
      roce_pkg::S_WALK: if (rd_idx_q == n_q && !cmp_vld_q) state_d = roce_pkg::S_PREP;
      roce_pkg::S_PREP: state_d = roce_pkg::S_RD;
      roce_pkg::S_RD:   state_d = roce_pkg::S_OUT;
      roce_pkg::S_OUT: begin
        if (out_free) state_d = (k_q == total_q - PW'(1)) ? roce_pkg::S_IDLE : roce_pkg::S_RD;
      end
      default: state_d = roce_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_i.ready  = (state_q == roce_pkg::S_IDLE);
    cfg_i.ready = 1'b1;
  end
  assign out_o.valid    = out_vld_q;
  assign out_o.out_char = out_char_q;
  assign out_o.status   = out_stat_q;
  assign out_o.last     = out_last_q;

  // Character at the current emission position.
  logic [roce_pkg::CharW-1:0] emit_char;
  logic [PW-1:0] dpos;
  logic [1:0]    dsel;
  always_comb begin
    dpos = k_q - colon_q;
    dsel = ndig_q - 2'd1 - dpos[1:0];
    if (k_q < colon_q) emit_char = roce_pkg::CH_COLON;
    else if (k_q < pfx_q) begin
      if (dec_q) begin
        case (dsel)
          2'd2:    emit_char = roce_pkg::CH_ZERO + {4'd0, bcd_q[11:8]};
          2'd1:    emit_char = roce_pkg::CH_ZERO + {4'd0, bcd_q[7:4]};
          default: emit_char = roce_pkg::CH_ZERO + {4'd0, bcd_q[3:0]};
        endcase
      end else emit_char = neg_q ? roce_pkg::CH_LT : roce_pkg::CH_GT;
    end else emit_char = code_rd_q;
  end

  logic [PW-1:0] code_addr;
  assign code_addr = base_q + k_q - pfx_q;

  // Subject table memory.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.action == roce_pkg::ACT_APPEND && cnt_q < CW'(MAX_SUBJECTS))
      subj_mem[AW'(cnt_q)] <= {in_i.range_start, in_i.range_width, in_i.range_space};
    subj_rd_q <= subj_mem[AW'(rd_idx_q)];
  end

  // Code row memory.
  always_ff @(posedge clk_i) begin
    if (cmp_vld_q) code_mem[cmp_idx_q] <= cmp_char;
    code_rd_q <= code_mem[code_addr[AW-1:0]];
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= roce_pkg::S_IDLE;
      mode_q    <= 1'b1;
      cnt_q     <= '0;
      lrc_q     <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      rd_idx_q  <= '0;
      found_q   <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) mode_q <= cfg_i.data;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;

      case (state_q)
        roce_pkg::S_IDLE: begin
          if (in_acc) begin
            qs_q     <= {{2{in_i.range_start[31]}}, in_i.range_start};
            qe_q     <= {{2{in_i.range_start[31]}}, in_i.range_start}
                        + $signed({3'b000, in_i.range_width});
            qsp_q    <= in_i.range_space;
            first_q  <= in_i.first_row;
            n_q      <= cnt_q;
            rd_idx_q <= '0;
            found_q  <= 1'b0;
            err_q    <= (in_i.action == roce_pkg::ACT_APPEND) ? roce_pkg::ST_FULL
                                                               : roce_pkg::ST_EMPTY;
            if (in_i.action == roce_pkg::ACT_APPEND && cnt_q < CW'(MAX_SUBJECTS))
              cnt_q <= cnt_q + CW'(1);
            if (in_i.action == roce_pkg::ACT_CLEAR) cnt_q <= '0;
          end
        end
        roce_pkg::S_ERR: begin
          if (out_free) begin
            out_char_q <= '0;
            out_stat_q <= err_q;
            out_last_q <= 1'b1;
          end
        end
        roce_pkg::S_WALK: begin
          cmp_vld_q <= (rd_idx_q != n_q);
          cmp_idx_q <= AW'(rd_idx_q);
          if (rd_idx_q != n_q) rd_idx_q <= rd_idx_q + CW'(1);
          if (cmp_vld_q) begin
            if (!found_q) begin
              if (cmp_char != roce_pkg::CH_M) begin
                found_q <= 1'b1;
                j1_q    <= CW'(cmp_idx_q) + CW'(1);
                j2_q    <= CW'(cmp_idx_q) + CW'(1);
              end
            end else if (cmp_char != roce_pkg::CH_A) begin
              j2_q <= CW'(cmp_idx_q) + CW'(1);
            end
          end else if (rd_idx_q == n_q && !found_q) begin
            j1_q <= n_q;
            j2_q <= n_q;
          end
        end
        roce_pkg::S_PREP: begin
          colon_q <= colon_w;
          pfx_q   <= colon_w + pre_w;
          total_q <= (sum_w > PW'(BUF)) ? PW'(BUF) : sum_w;
          base_q  <= base_w;
          dec_q   <= (lrc_eff == '0);
          neg_q   <= (shift_w < 0);
          ndig_q  <= ndig_w;
          bcd_q   <= bcd_w;
          k_q     <= '0;
          if (mode_q) lrc_q <= j2w[roce_pkg::LrcW-1:0];
        end
        roce_pkg::S_OUT: begin
          if (out_free) begin
            out_char_q <= emit_char;
            out_stat_q <= roce_pkg::ST_OK;
            out_last_q <= (k_q == total_q - PW'(1));
            k_q        <= k_q + PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SUBJECTS)) else $error("subject count above table depth");
  a_cmp_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> state_q == roce_pkg::S_WALK) else $error("compare outside walk");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stat_q != roce_pkg::ST_OK |-> out_last_q)
    else $error("status word not marked last");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == roce_pkg::S_OUT |-> k_q < total_q) else $error("emission past row end");
`endif

endmodule

// ===== dv/tb_range_overlap_code_encoder_core.sv =====
`timescale 1ns / 1ps
module tb_range_overlap_code_encoder_core;

  localparam int unsigned NumSubjects = 16;
  localparam int unsigned ItemTarget  = 460;
  localparam int unsigned SettleCyc   = 120;
  localparam longint unsigned CycleLimit = 1_500_000;

  typedef struct packed {
    logic [roce_pkg::CharW-1:0] out_char;
    logic [roce_pkg::StatW-1:0] status;
    logic                       last;
  } code_word_t;

  // Tracks the subject table and predicts the code words of every accepted word.
  class code_row_board;
    logic signed [roce_pkg::StartW-1:0] subj_start [NumSubjects];
    logic [roce_pkg::WidthW-1:0]        subj_width [NumSubjects];
    logic signed [roce_pkg::SpaceW-1:0] subj_space [NumSubjects];
    int unsigned              subj_count;
    int unsigned              last_col;
    bit                       sparse;
    code_word_t               pending [$];
    int unsigned              errors;

    function new();
      subj_count = 0;
      last_col   = 0;
      sparse     = 1'b1;
      errors     = 0;
    endfunction

    // Overlap letter of the query against one subject, with ends wide enough not to wrap.
    function logic [roce_pkg::CharW-1:0] overlap_letter(longint qs, longint qw, longint ss,
                                                        longint sw);
      longint qe;
      longint se;
      int     c;
      qe = qs + qw;
      se = ss + sw;
      if (qe < ss) c = -6;
      else if (qe == ss) c = -5;
      else if (se < qs) c = 6;
      else if (se == qs) c = 5;
      else begin
        qe--;
        se--;
        if (qs < ss) c = (qe < se) ? -4 : ((qe == se) ? -3 : -2);
        else if (qs == ss) c = (qe < se) ? -1 : ((qe == se) ? 0 : 1);
        else c = (qe < se) ? 2 : ((qe == se) ? 3 : 4);
      end
      return roce_pkg::CharW'(int'(roce_pkg::CH_G) + c);
    endfunction

    function void push_row(logic [roce_pkg::CharW-1:0] row [$]);
      code_word_t w;
      foreach (row[k]) begin
        w.out_char = row[k];
        w.status   = roce_pkg::ST_OK;
        w.last     = (k == row.size() - 1);
        pending.push_back(w);
      end
    endfunction

    function void push_status(logic [roce_pkg::StatW-1:0] st);
      code_word_t w;
      w.out_char = '0;
      w.status   = st;
      w.last     = 1'b1;
      pending.push_back(w);
    endfunction

    // Notes one accepted input word and queues the code words it should produce.
    function void note_input(logic [roce_pkg::ActW-1:0] act,
                             logic signed [roce_pkg::StartW-1:0] st,
                             logic [roce_pkg::WidthW-1:0] wd,
                             logic signed [roce_pkg::SpaceW-1:0] sp,
                             logic first);
      logic [roce_pkg::CharW-1:0] codes [$];
      logic [roce_pkg::CharW-1:0] row [$];
      int j1;
      int j2;
      int shift;
      if (act == roce_pkg::ACT_APPEND) begin
        if (subj_count >= NumSubjects) begin
          push_status(roce_pkg::ST_FULL);
        end else begin
          subj_start[subj_count] = st;
          subj_width[subj_count] = wd;
          subj_space[subj_count] = sp;
          subj_count++;
        end
        return;
      end
      if (act == roce_pkg::ACT_CLEAR) begin
        subj_count = 0;
        return;
      end
      if (act != roce_pkg::ACT_QUERY) return;

      for (int j = 0; j < subj_count; j++) begin
        if (sp == -1 || subj_space[j] == -1 || sp != subj_space[j])
          codes.push_back(roce_pkg::CH_X);
        else codes.push_back(overlap_letter(longint'(st), longint'({1'b0, wd}),
                                            longint'(subj_start[j]),
                                            longint'({1'b0, subj_width[j]})));
      end
      if (!sparse) begin
        push_row(codes);
        return;
      end
      if (subj_count == 0) begin
        push_status(roce_pkg::ST_EMPTY);
        return;
      end

      // First reported column skips the leading 'm' run; last one drops the trailing 'a' run.
      j1 = subj_count;
      for (int j = 0; j < subj_count; j++) begin
        if (codes[j] != roce_pkg::CH_M) begin
          j1 = j + 1;
          break;
        end
      end
      j2 = j1;
      for (int j = j1; j < subj_count; j++) if (codes[j] != roce_pkg::CH_A) j2 = j + 1;

      if (first) last_col = 0;
      else row.push_back(roce_pkg::CH_COLON);
      if (last_col == 0) begin
        if (j1 >= 10) row.push_back(roce_pkg::CharW'(int'(roce_pkg::CH_ZERO) + j1 / 10));
        row.push_back(roce_pkg::CharW'(int'(roce_pkg::CH_ZERO) + j1 % 10));
      end else begin
        shift = j1 - int'(last_col) - 1;
        while (shift > 0) begin
          row.push_back(roce_pkg::CH_GT);
          shift--;
        end
        while (shift < 0) begin
          row.push_back(roce_pkg::CH_LT);
          shift++;
        end
      end
      for (int j = j1 - 1; j < j2; j++) row.push_back(codes[j]);
      last_col = j2 & 31;
      push_row(row);
    endfunction

    // Compares one accepted code word with the oldest prediction.
    function void check_result(logic [roce_pkg::CharW-1:0] ch, logic [roce_pkg::StatW-1:0] st,
                               logic lst);
      code_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word char=%h status=%0d last=%0b", $time, ch, st, lst);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (exp_w.out_char !== ch) begin
        $display("%0t: out_char expected %h actual %h", $time, exp_w.out_char, ch);
        errors++;
      end
      if (exp_w.status !== st) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_w.status, st);
        errors++;
      end
      if (exp_w.last !== lst) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_w.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  roce_cfg_if cfg_if ();
  roce_in_if  in_if ();
  roce_out_if out_if ();

  range_overlap_code_encoder_core #(
    .MAX_SUBJECTS(NumSubjects)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  code_row_board board;
  bit            no_idle;
  int unsigned   sent;
  longint unsigned cycles;
  logic [31:0]   ph_base;
  logic [31:0]   ph_space;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_result(out_if.out_char, out_if.status, out_if.last);
  end

  // Result receiver with random stalls.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Sends one input word after a random gap.
  task automatic send_word(logic [roce_pkg::ActW-1:0] act, logic [31:0] st, logic [30:0] wd,
                           logic [31:0] sp, logic first);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.range_start <= st;
    in_if.range_width <= wd;
    in_if.range_space <= sp;
    in_if.first_row   <= first;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(act, st, wd, sp, first);
    if (act != roce_pkg::ACT_RSVD) sent++;
  endtask

  // Lets every expected word arrive and the block settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= mode;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.sparse = mode;
  endtask

  // Random range clustered around the phase base so that all overlap classes appear.
  task automatic send_range(logic [roce_pkg::ActW-1:0] act, logic first);
    logic [31:0] st;
    logic [30:0] wd;
    logic [31:0] sp;
    int unsigned pick;
    st = ph_base + $urandom_range(0, 40);
    wd = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 16));
    pick = $urandom_range(0, 9);
    if (pick <= 6) sp = ph_space;
    else if (pick == 7) sp = $urandom_range(0, 2);
    else if (pick == 8) sp = '1;
    else sp = $urandom;
    if ($urandom_range(0, 19) == 0) st = $urandom;
    send_word(act, st, wd, sp, first);
  endtask

  initial begin
    int unsigned nsub;
    int unsigned nq;
    board        = new();
    no_idle      = 1'b0;
    sent         = 0;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = roce_pkg::ACT_APPEND;
    in_if.range_start = '0;
    in_if.range_width = '0;
    in_if.range_space = '0;
    in_if.first_row   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table in both modes, extremes, unused action, full table.
    send_word(roce_pkg::ACT_QUERY, 32'd5, 31'd3, 32'd0, 1'b0);
    send_word(roce_pkg::ACT_RSVD, '1, '1, '1, 1'b1);
    write_mode(1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'd5, 31'd3, 32'd0, 1'b1);
    send_word(roce_pkg::ACT_APPEND, 32'h8000_0000, 31'h7fff_ffff, 32'd0, 1'b0);
    send_word(roce_pkg::ACT_APPEND, 32'h7fff_ffff, 31'h7fff_ffff, 32'd0, 1'b1);
    send_word(roce_pkg::ACT_APPEND, 32'd100, 31'd10, '1, 1'b0);
    send_word(roce_pkg::ACT_APPEND, 32'd100, 31'd10, 32'h8000_0000, 1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'h7fff_ffff, 31'h7fff_ffff, 32'd0, 1'b1);
    send_word(roce_pkg::ACT_QUERY, 32'h8000_0000, 31'd0, 32'd0, 1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'd100, 31'd10, 32'h8000_0000, 1'b0);
    write_mode(1'b1);
    send_word(roce_pkg::ACT_QUERY, 32'd100, 31'd10, 32'h8000_0000, 1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'h7fff_ffff, 31'd1, 32'd0, 1'b1);
    for (int k = 0; k < 13; k++)
      send_word(roce_pkg::ACT_APPEND, 32'(k * 3), 31'd2, 32'd7, 1'b0);
    send_word(roce_pkg::ACT_APPEND, 32'd0, 31'd0, 32'd7, 1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'd60, 31'd2, 32'd7, 1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'hffff_fff0, 31'd1, 32'd7, 1'b0);
    send_word(roce_pkg::ACT_CLEAR, 32'd0, 31'd0, 32'd0, 1'b0);
    send_word(roce_pkg::ACT_APPEND, 32'd20, 31'd4, 32'd7, 1'b0);
    send_word(roce_pkg::ACT_QUERY, 32'd10, 31'd2, 32'd7, 1'b0);

    // Random phases: load a table, then a set of queries.
    while (sent < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 4) == 0) wait_idle();
      no_idle  = ($urandom_range(0, 5) == 0);
      ph_base  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 200);
      ph_space = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2);
      if ($urandom_range(0, 5) != 0)
        send_word(roce_pkg::ACT_CLEAR, $urandom, 31'($urandom), $urandom, 1'b0);
      nsub = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 8);
      for (int k = 0; k < nsub; k++)
        send_range(roce_pkg::ACT_APPEND, 1'($urandom_range(0, 1)));
      nq = $urandom_range(2, 8);
      for (int k = 0; k < nq; k++) begin
        case ($urandom_range(0, 11))
          0: send_word(roce_pkg::ACT_RSVD, $urandom, 31'($urandom), $urandom,
                       1'($urandom_range(0, 1)));
          1: send_range(roce_pkg::ACT_APPEND, 1'b0);
          2: send_word(roce_pkg::ACT_CLEAR, $urandom, 31'($urandom), $urandom, 1'b0);
          default: send_range(roce_pkg::ACT_QUERY, (k == 0) ? ($urandom_range(0, 4) != 0) :
                                                              ($urandom_range(0, 6) == 0));
        endcase
      end
    end
    no_idle = 1'b0;

    wait_idle();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
